>>> design/nmea_rmc_field_extractor_assert.svh
// Assertion macros shared by the NMEA RMC extractor checks.
`ifndef NMEA_RMC_FIELD_EXTRACTOR_ASSERT_SVH
`define NMEA_RMC_FIELD_EXTRACTOR_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define NRMC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define NRMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/nrmc_pkg.sv
// Types, constants and field lookup for the NMEA RMC field extractor.
`timescale 1ns / 1ps
`default_nettype none
package nrmc_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [2:0] t_fill;
    typedef logic [3:0] t_count4;

    typedef enum logic [2:0] {
        FC_TIME = 3'd0,
        FC_LAT  = 3'd1,
        FC_NS   = 3'd2,
        FC_LON  = 3'd3,
        FC_EW   = 3'd4,
        FC_DATE = 3'd5
    } t_field_code;

    typedef struct packed {
        logic        emit;
        t_field_code code;
        t_count4     cap;
    } t_field_info;

    localparam int HDR_LEN = 7;
    localparam logic [8*HDR_LEN-1:0] HDR_PATTERN = "$GPRMC,";
    localparam t_byte CHAR_STAR = 8'h2A;
    localparam t_byte CHAR_COMMA = 8'h2C;
    localparam t_count4 COUNT_MAX = 4'd15;

    localparam t_count4 TIME_DATE_CHARS = 4'd9;
    localparam t_count4 COORD_CHARS = 4'd14;
    localparam t_count4 FLAG_CHARS = 4'd1;

    localparam t_count4 NMEA_TIME = 4'd1;
    localparam t_count4 NMEA_LAT = 4'd3;
    localparam t_count4 NMEA_NS = 4'd4;
    localparam t_count4 NMEA_LON = 4'd5;
    localparam t_count4 NMEA_EW = 4'd6;
    localparam t_count4 NMEA_DATE = 4'd9;

    function automatic t_field_info field_info(input t_count4 fnum);
        t_field_info info;
        info = '{emit: 1'b0, code: FC_TIME, cap: 4'd0};
        case (fnum)
            NMEA_TIME: info = '{emit: 1'b1, code: FC_TIME, cap: TIME_DATE_CHARS};
            NMEA_LAT:  info = '{emit: 1'b1, code: FC_LAT,  cap: COORD_CHARS};
            NMEA_NS:   info = '{emit: 1'b1, code: FC_NS,   cap: FLAG_CHARS};
            NMEA_LON:  info = '{emit: 1'b1, code: FC_LON,  cap: COORD_CHARS};
            NMEA_EW:   info = '{emit: 1'b1, code: FC_EW,   cap: FLAG_CHARS};
            NMEA_DATE: info = '{emit: 1'b1, code: FC_DATE, cap: TIME_DATE_CHARS};
            default:   info = '{emit: 1'b0, code: FC_TIME, cap: 4'd0};
        endcase
        return info;
    endfunction

endpackage
`default_nettype wire

>>> design/nmea_rmc_field_extractor.sv
// Top level of the NMEA RMC field extractor: header detection and field tagging.
// An accepted byte beat waits in the input register; its result is registered at the output when it advances.
// Throughput: one byte beat per cycle unless o_stall is raised; each byte is handled in the single decode stage.
// The input register takes a new beat while a finished result waits at the output, unless its own beat has a result.
// Reset is synchronous and active low; it clears the header window and all counters.
// After reset no sentence is open until a complete header has been received.
`timescale 1ns / 1ps
`default_nettype none
module nmea_rmc_field_extractor #(
    parameter int MAX_CAPTURE = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire  nrmc_pkg::t_byte i_rx_byte,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [2:0]           o_field_code,
    output logic [7:0]           o_field_char,
    output logic [3:0]           o_char_offset,
    output logic                 o_sentence_end
);
    import nrmc_pkg::*;

    localparam int CW = $clog2(MAX_CAPTURE + 1);
    localparam logic [CW-1:0] CAPTURE_LIMIT = CW'(MAX_CAPTURE);
    localparam t_fill FILL_FULL = t_fill'(HDR_LEN);

    logic                   r_in_valid;
    t_byte                  r_in_byte;
    logic [8*HDR_LEN-1:0]   r_win;
    t_fill                  r_fill;
    logic                   r_in_sent;
    logic [CW-1:0]          r_captured;
    t_count4                r_field;
    t_count4                r_offset;
    logic                   r_out_valid;
    t_field_code            r_out_code;
    t_byte                  r_out_char;
    t_count4                r_out_off;
    logic                   r_out_end;

    logic [8*HDR_LEN-1:0]   n_win;
    t_fill                  n_fill;
    logic                   n_in_sent;
    logic [CW-1:0]          n_captured;
    t_count4                n_field;
    t_count4                n_offset;
    logic                   res_valid;
    t_field_code            res_code;
    t_byte                  res_char;
    t_count4                res_off;
    logic                   res_end;
    logic                   out_ready;
    logic                   adv;
    t_field_info            info;

    always_comb begin
        n_win      = {r_win[8*HDR_LEN-9:0], r_in_byte};
        n_fill     = (r_fill == FILL_FULL) ? r_fill : r_fill + 3'd1;
        n_in_sent  = r_in_sent;
        n_captured = r_captured;
        n_field    = r_field;
        n_offset   = r_offset;
        res_valid  = 1'b0;
        res_code   = FC_TIME;
        res_char   = 8'd0;
        res_off    = 4'd0;
        res_end    = 1'b0;
        info       = field_info(r_field);
        if (n_fill == FILL_FULL && n_win == HDR_PATTERN) begin
            n_in_sent  = 1'b1;
            n_captured = '0;
            n_field    = NMEA_TIME;
            n_offset   = 4'd0;
        end else if (r_in_sent) begin
            if (r_in_byte == CHAR_STAR) begin
                n_in_sent = 1'b0;
                res_valid = 1'b1;
                res_end   = 1'b1;
            end else if (r_captured < CAPTURE_LIMIT) begin
                n_captured = r_captured + 1'b1;
                if (r_in_byte == CHAR_COMMA) begin
                    n_field  = (r_field == COUNT_MAX) ? r_field : r_field + 4'd1;
                    n_offset = 4'd0;
                end else begin
                    n_offset = (r_offset == COUNT_MAX) ? r_offset : r_offset + 4'd1;
                    if (info.emit && r_offset < info.cap) begin
                        res_valid = 1'b1;
                        res_code  = info.code;
                        res_char  = r_in_byte;
                        res_off   = r_offset;
                    end
                end
            end
        end
    end

    assign out_ready = !r_out_valid || !i_stall;
    assign adv       = r_in_valid && (out_ready || !res_valid);
    assign o_stall   = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_fill     <= '0;
            r_in_sent  <= 1'b0;
            r_captured <= '0;
            r_field    <= 4'd0;
            r_offset   <= 4'd0;
        end else if (adv) begin
            r_win      <= n_win;
            r_fill     <= n_fill;
            r_in_sent  <= n_in_sent;
            r_captured <= n_captured;
            r_field    <= n_field;
            r_offset   <= n_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res_valid) begin
            r_out_code <= res_code;
            r_out_char <= res_char;
            r_out_off  <= res_off;
            r_out_end  <= res_end;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_field_code   = r_out_code;
    assign o_field_char   = r_out_char;
    assign o_char_offset  = r_out_off;
    assign o_sentence_end = r_out_end;

endmodule
`default_nettype wire

>>> design/nrmc_checker.sv
// Port-level assertions for the NMEA RMC field extractor and their bind.
`timescale 1ns / 1ps
`default_nettype none
`include "nmea_rmc_field_extractor_assert.svh"
module nrmc_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_valid,
    input wire                  i_stall,
    input wire [2:0]            o_field_code,
    input wire [7:0]            o_field_char,
    input wire [3:0]            o_char_offset,
    input wire                  o_sentence_end
);
    import nrmc_pkg::*;

    `NRMC_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_field_code) && $stable(o_field_char) && $stable(o_char_offset) && $stable(o_sentence_end), "Stalled result beat changed")
    `NRMC_ASSERT_SAME(a_end_empty, o_valid && o_sentence_end, o_field_code == 3'd0 && o_field_char == 8'd0 && o_char_offset == 4'd0, "End marker carries data")
    `NRMC_ASSERT_SAME(a_flag_single, o_valid && !o_sentence_end && (o_field_code == FC_NS || o_field_code == FC_EW), o_char_offset == 4'd0, "Flag field beyond one character")
    `NRMC_ASSERT_SAME(a_time_cap, o_valid && !o_sentence_end && (o_field_code == FC_TIME || o_field_code == FC_DATE), o_char_offset < TIME_DATE_CHARS, "Time or date beyond its cap")

endmodule

bind nmea_rmc_field_extractor nrmc_checker u_nrmc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_field_code   (o_field_code),
    .o_field_char   (o_field_char),
    .o_char_offset  (o_char_offset),
    .o_sentence_end (o_sentence_end)
);
`default_nettype wire

>>> test/nmea_rmc_field_extractor_tb.sv
// Self-checking testbench for the NMEA RMC field extractor with random stalls on both sides.
`timescale 1ns / 1ps
module nmea_rmc_field_extractor_tb;
    import nrmc_pkg::*;

    localparam int CAPTURE_LIMIT = 64;
    localparam int BYTE_TARGET = 1850;

    typedef struct {
        t_field_code code;
        t_byte       ch;
        logic [3:0]  offset;
        logic        fin;
    } t_rmc_beat;

    class rmc_scoreboard;
        logic [8*HDR_LEN-1:0] window;
        int unsigned          window_fill;
        bit                   in_sentence;
        int unsigned          taken;
        logic [3:0]           field_num;
        logic [3:0]           field_pos;
        t_rmc_beat            due_beats[$];
        int                   errors;

        function new();
            window = '0;
            window_fill = 0;
            in_sentence = 0;
            taken = 0;
            field_num = '0;
            field_pos = '0;
            errors = 0;
        endfunction

        function bit field_tag(input logic [3:0] fnum, output t_field_code code,
                               output logic [3:0] cap);
            code = FC_TIME;
            cap = '0;
            case (fnum)
                4'd1: begin
                    code = FC_TIME;
                    cap = TIME_DATE_CHARS;
                end
                4'd3: begin
                    code = FC_LAT;
                    cap = COORD_CHARS;
                end
                4'd4: begin
                    code = FC_NS;
                    cap = 4'd1;
                end
                4'd5: begin
                    code = FC_LON;
                    cap = COORD_CHARS;
                end
                4'd6: begin
                    code = FC_EW;
                    cap = 4'd1;
                end
                4'd9: begin
                    code = FC_DATE;
                    cap = TIME_DATE_CHARS;
                end
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function void note_byte(input t_byte c);
            t_rmc_beat   beat;
            t_field_code code;
            logic [3:0]  cap;
            logic [3:0]  pos;
            window = {window[8*HDR_LEN-9:0], c};
            if (window_fill < HDR_LEN)
                window_fill++;
            if (window_fill == HDR_LEN && window == HDR_PATTERN) begin
                in_sentence = 1;
                taken = 0;
                field_num = 4'd1;
                field_pos = 4'd0;
                return;
            end
            if (!in_sentence)
                return;
            if (c == CHAR_STAR) begin
                in_sentence = 0;
                beat = '{code: FC_TIME, ch: 8'h00, offset: 4'd0, fin: 1'b1};
                due_beats.push_back(beat);
                return;
            end
            if (taken >= CAPTURE_LIMIT)
                return;
            taken++;
            if (c == CHAR_COMMA) begin
                if (field_num != COUNT_MAX)
                    field_num++;
                field_pos = 4'd0;
                return;
            end
            pos = field_pos;
            if (field_pos != COUNT_MAX)
                field_pos++;
            if (field_tag(field_num, code, cap) && pos < cap) begin
                beat = '{code: code, ch: c, offset: pos, fin: 1'b0};
                due_beats.push_back(beat);
            end
        endfunction

        function void check_result(input logic [2:0] code, input t_byte ch,
                                   input logic [3:0] offset, input logic fin);
            t_rmc_beat want;
            if (due_beats.size() == 0) begin
                $display("%0t: result beat with none due: code %0d char %h offset %0d end %b",
                         $time, code, ch, offset, fin);
                errors++;
                return;
            end
            want = due_beats.pop_front();
            if (code !== want.code) begin
                $display("%0t: field_code expected %0d actual %0d", $time, want.code, code);
                errors++;
            end
            if (ch !== want.ch) begin
                $display("%0t: field_char expected %h actual %h", $time, want.ch, ch);
                errors++;
            end
            if (offset !== want.offset) begin
                $display("%0t: char_offset expected %0d actual %0d", $time, want.offset,
                         offset);
                errors++;
            end
            if (fin !== want.fin) begin
                $display("%0t: sentence_end expected %b actual %b", $time, want.fin, fin);
                errors++;
            end
        endfunction

        function int outstanding();
            return due_beats.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    t_byte      i_rx_byte = 8'h00;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [2:0] o_field_code;
    logic [7:0] o_field_char;
    logic [3:0] o_char_offset;
    logic       o_sentence_end;

    rmc_scoreboard sb = new();
    int  bytes_sent = 0;
    int  hold_left = 0;
    bit  tx_steady = 0;
    bit  rx_steady = 0;

    nmea_rmc_field_extractor #(
        .MAX_CAPTURE(CAPTURE_LIMIT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_rx_byte(i_rx_byte),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_field_code(o_field_code),
        .o_field_char(o_field_char),
        .o_char_offset(o_char_offset),
        .o_sentence_end(o_sentence_end)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            sb.note_byte(i_rx_byte);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_field_code, o_field_char, o_char_offset, o_sentence_end);
            hold_left = rx_steady ? 0 : $urandom_range(0, 14);
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_byte(input t_byte b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_byte(t_byte'(s[k]));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        // The last accepted beat is noted at this same edge, so look after it settles.
        @(negedge i_clk);
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_byte field_byte();
        t_byte b;
        case ($urandom_range(0, 15))
            0: b = t_byte'($urandom_range(0, 255));
            1: b = "N";
            2: b = "E";
            3: b = ".";
            default: b = t_byte'($urandom_range("0", "9"));
        endcase
        return b;
    endfunction

    task automatic send_sentence();
        int nfields;
        int flen;
        send_text("$GPRMC,");
        nfields = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 18) : $urandom_range(8, 12);
        for (int f = 1; f <= nfields; f++) begin
            if (f == 4 || f == 6)
                flen = $urandom_range(0, 2);
            else if ($urandom_range(0, 4) == 0)
                flen = $urandom_range(0, 17);
            else
                flen = $urandom_range(0, 8);
            repeat (flen) send_byte(field_byte());
            if (f < nfields)
                send_byte(CHAR_COMMA);
            if ($urandom_range(0, 60) == 0)
                send_text("$GPRMC,");
        end
        if ($urandom_range(0, 7) != 0) begin
            send_byte(CHAR_STAR);
            send_text("4F\r\n");
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 12);
        repeat (n) begin
            case ($urandom_range(0, 7))
                0: send_byte(CHAR_STAR);
                1: send_text("$GPRM");
                default: send_byte(t_byte'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin
        int next_drain;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_byte(CHAR_STAR);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("$GPRMC,");
        send_text("9,,4,NS,E*");
        next_drain = 400;
        while (bytes_sent < BYTE_TARGET) begin
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0)
                send_noise();
            else
                send_sentence();
            if (bytes_sent >= next_drain) begin
                wait_drained();
                next_drain += 400;
            end
        end
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
